[design/ldke_pkg.sv]
package ldke_pkg;

  // Configuration register widths and reset values.
  localparam int MinWeightW = 18;
  localparam int ThrW       = 8;
  localparam int CfgDataW   = 18;
  localparam int CfgIdxW    = 2;

  localparam logic [MinWeightW-1:0] MinWeightRst = 18'd2500;
  localparam logic [ThrW-1:0]       ThrRst       = 8'd77;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WEIGHT_FLOOR = 2'd0,
    CFG_X_THRESHOLD  = 2'd1,
    CFG_Y_THRESHOLD  = 2'd2
  } cfg_idx_e;

  // Held direction of one axis.
  typedef enum logic [1:0] {
    DIR_NEUTRAL = 2'd0,
    DIR_POS     = 2'd1,
    DIR_NEG     = 2'd2
  } dir_e;

  // Key codes carried on the result channel.
  typedef enum logic [1:0] {
    KEY_LEFT  = 2'd0,
    KEY_RIGHT = 2'd1,
    KEY_UP    = 2'd2,
    KEY_DOWN  = 2'd3
  } key_e;

  // Outcome of one axis for one sample.
  typedef struct packed {
    logic vld;
    key_e key;
    logic pressed;
    dir_e dir;
  } axis_res_t;

endpackage

[design/ldke_sample_if.sv]
interface ldke_sample_if #(
  parameter int LOAD_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic                 board_present;
  logic [LOAD_BITS-1:0] top_left_load;
  logic [LOAD_BITS-1:0] top_right_load;
  logic [LOAD_BITS-1:0] bottom_left_load;
  logic [LOAD_BITS-1:0] bottom_right_load;

  modport source (
    output valid, board_present, top_left_load, top_right_load,
           bottom_left_load, bottom_right_load,
    input  ready
  );

  modport sink (
    input  valid, board_present, top_left_load, top_right_load,
           bottom_left_load, bottom_right_load,
    output ready
  );
endinterface

[design/ldke_key_if.sv]
interface ldke_key_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_code;
  logic       pressed;
  logic       last_event;

  modport source (
    output valid, key_code, pressed, last_event,
    input  ready
  );

  modport sink (
    input  valid, key_code, pressed, last_event,
    output ready
  );
endinterface

[design/ldke_axis.sv]
module ldke_axis import ldke_pkg::*; #(
  parameter int LOAD_BITS = 16
) (
  input  dir_e                 dir_i,
  input  logic                 heavy_i,
  input  logic [LOAD_BITS:0]   pair_i,
  input  logic [LOAD_BITS+1:0] total_i,
  input  logic [ThrW-1:0]      thr_i,
  input  key_e                 pos_key_i,
  input  key_e                 neg_key_i,
  output axis_res_t            res_o
);

  localparam int TotW  = LOAD_BITS + 2;
  localparam int LeanW = LOAD_BITS + 12;

  logic signed [LeanW-1:0] pair2_s;
  logic signed [LeanW-1:0] total_s;
  logic signed [LeanW-1:0] lean;
  logic signed [LeanW-1:0] lim;
  logic signed [LeanW-1:0] neg_lim;
  logic [ThrW+TotW-1:0]    prod;
  logic                    lean_pos;
  logic                    lean_neg;
  logic                    dead_zone;

  // Lean of the axis scaled by 256, and the threshold scaled by the total.
  always_comb begin
    pair2_s = LeanW'({pair_i, 1'b0});
    total_s = LeanW'(total_i);
    lean    = (pair2_s - total_s) <<< ThrW;
    prod    = thr_i * total_i;
    lim     = LeanW'(prod);
    neg_lim = -lim;
  end

  // A light sample counts as the dead zone so that a held key is released.
  assign lean_pos  = heavy_i && (lean > lim);
  assign lean_neg  = heavy_i && (lean < neg_lim);
  assign dead_zone = !heavy_i || ((lean > neg_lim) && (lean < lim));

  // Press on a new lean, release when the axis returns to the dead zone.
  always_comb begin
    res_o.vld     = 1'b0;
    res_o.key     = pos_key_i;
    res_o.pressed = 1'b0;
    res_o.dir     = dir_i;
    if (lean_pos && (dir_i != DIR_POS)) begin
      res_o.vld     = 1'b1;
      res_o.pressed = 1'b1;
      res_o.dir     = DIR_POS;
    end else if (lean_neg && (dir_i != DIR_NEG)) begin
      res_o.vld     = 1'b1;
      res_o.key     = neg_key_i;
      res_o.pressed = 1'b1;
      res_o.dir     = DIR_NEG;
    end else if (dead_zone) begin
      if (dir_i == DIR_POS) begin
        res_o.vld = 1'b1;
        res_o.dir = DIR_NEUTRAL;
      end else if (dir_i == DIR_NEG) begin
        res_o.vld = 1'b1;
        res_o.key = neg_key_i;
        res_o.dir = DIR_NEUTRAL;
      end
    end
  end

endmodule

[design/lean_direction_key_events_core.sv]
// Lean direction key events core.
// Samples of four corner load cells come in on sample_i; key press and
// release items leave on key_o, at most two per sample, the x axis first.
// The last item of a sample has last_event set. A sample with
// board_present low, or one that changes nothing, yields no item.
// Thresholds and the minimum weight are set through the write port
// (cfg_we_i, cfg_idx_i, cfg_data_i); the user writes them only while the
// block is idle, which the block itself does not enforce. A sample is
// taken into the input register; its items are decided from that register
// and written to the key queue when the register advances.
// One sample per cycle is taken while the queue has room for two items
// and each sample gives at most one; the two items of a sample leave one
// after the other on the single key_o port.
// The key queue holds four items. The input register moves on only while
// the queue has room for two, so a stalled receiver backs up into
// sample_i.ready without losing items.
// Reset clears both axes to neutral, empties the queue and loads the
// register defaults (minimum weight 2500, thresholds 77/256).
module lean_direction_key_events_core import ldke_pkg::*; #(
  parameter int LOAD_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ldke_sample_if.sink         sample_i,
  ldke_key_if.source          key_o
);

  localparam int TotW     = LOAD_BITS + 2;
  localparam int PairW    = LOAD_BITS + 1;
  localparam int CmpW     = (TotW > MinWeightW) ? TotW : MinWeightW;
  localparam int EvqDepth = 4;
  localparam int EvqAw    = $clog2(EvqDepth);
  localparam int EvqCntW  = $clog2(EvqDepth + 1);

  typedef struct packed {
    key_e key_code;
    logic pressed;
    logic last_event;
  } key_item_t;

  // Configuration registers.
  logic [MinWeightW-1:0] weight_floor_q;
  logic [ThrW-1:0]       x_thr_q;
  logic [ThrW-1:0]       y_thr_q;

  // Input register.
  logic                 s1_vld_q;
  logic                 s1_present_q;
  logic [LOAD_BITS-1:0] s1_tl_q;
  logic [LOAD_BITS-1:0] s1_tr_q;
  logic [LOAD_BITS-1:0] s1_bl_q;
  logic [LOAD_BITS-1:0] s1_br_q;

  // Axis state.
  dir_e h_dir_q;
  dir_e v_dir_q;

  // Key queue.
  key_item_t          evq_q [EvqDepth];
  logic [EvqAw-1:0]   wr_ptr_q, wr_ptr_d;
  logic [EvqAw-1:0]   rd_ptr_q, rd_ptr_d;
  logic [EvqCntW-1:0] cnt_q, cnt_d;

  logic            sample_fire;
  logic            s1_fire;
  logic            s1_use;
  logic            pop;
  logic            heavy;
  logic [TotW-1:0] total;
  logic [PairW-1:0] pair_x;
  logic [PairW-1:0] pair_y;
  axis_res_t       x_res;
  axis_res_t       y_res;
  logic            ev_x_vld;
  logic            ev_y_vld;
  logic [1:0]      push_cnt;
  key_item_t       first_item;
  key_item_t       second_item;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_floor_q <= MinWeightRst;
      x_thr_q        <= ThrRst;
      y_thr_q        <= ThrRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WEIGHT_FLOOR: weight_floor_q <= cfg_data_i[MinWeightW-1:0];
        CFG_X_THRESHOLD:  x_thr_q        <= cfg_data_i[ThrW-1:0];
        CFG_Y_THRESHOLD:  y_thr_q        <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // The input register advances while the queue has room for two items.
  assign s1_fire        = s1_vld_q && (cnt_q <= EvqCntW'(EvqDepth - 2));
  assign sample_i.ready = !s1_vld_q || s1_fire;
  assign sample_fire    = sample_i.valid && sample_i.ready;
  assign s1_use         = s1_fire && s1_present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_vld_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_fire) begin
      s1_present_q <= sample_i.board_present;
      s1_tl_q      <= sample_i.top_left_load;
      s1_tr_q      <= sample_i.top_right_load;
      s1_bl_q      <= sample_i.bottom_left_load;
      s1_br_q      <= sample_i.bottom_right_load;
    end
  end

  // Total load, pair loads and the weight test.
  assign total  = TotW'(s1_tl_q) + TotW'(s1_tr_q) + TotW'(s1_bl_q) + TotW'(s1_br_q);
  assign pair_x = PairW'(s1_tr_q) + PairW'(s1_br_q);
  assign pair_y = PairW'(s1_tl_q) + PairW'(s1_tr_q);
  assign heavy  = CmpW'(total) > CmpW'(weight_floor_q);

  ldke_axis #(.LOAD_BITS(LOAD_BITS)) u_axis_x (
    .dir_i     (h_dir_q),
    .heavy_i   (heavy),
    .pair_i    (pair_x),
    .total_i   (total),
    .thr_i     (x_thr_q),
    .pos_key_i (KEY_RIGHT),
    .neg_key_i (KEY_LEFT),
    .res_o     (x_res)
  );

  ldke_axis #(.LOAD_BITS(LOAD_BITS)) u_axis_y (
    .dir_i     (v_dir_q),
    .heavy_i   (heavy),
    .pair_i    (pair_y),
    .total_i   (total),
    .thr_i     (y_thr_q),
    .pos_key_i (KEY_UP),
    .neg_key_i (KEY_DOWN),
    .res_o     (y_res)
  );

  assign ev_x_vld = s1_use && x_res.vld;
  assign ev_y_vld = s1_use && y_res.vld;

  // Direction state follows the axis decisions of each used sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_dir_q <= DIR_NEUTRAL;
      v_dir_q <= DIR_NEUTRAL;
    end else if (s1_use) begin
      h_dir_q <= x_res.dir;
      v_dir_q <= y_res.dir;
    end
  end

  // Items of one sample in order: x first, the last one flagged.
  always_comb begin
    first_item.key_code   = ev_x_vld ? x_res.key : y_res.key;
    first_item.pressed    = ev_x_vld ? x_res.pressed : y_res.pressed;
    first_item.last_event = !(ev_x_vld && ev_y_vld);
    second_item.key_code   = y_res.key;
    second_item.pressed    = y_res.pressed;
    second_item.last_event = 1'b1;
  end

  // Queue pointers and fill count.
  assign pop      = key_o.valid && key_o.ready;
  assign push_cnt = {1'b0, ev_x_vld} + {1'b0, ev_y_vld};

  always_comb begin
    wr_ptr_d = wr_ptr_q + EvqAw'(push_cnt);
    rd_ptr_d = rd_ptr_q + EvqAw'(pop);
    cnt_d    = cnt_q + EvqCntW'(push_cnt) - EvqCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_x_vld || ev_y_vld) begin
      evq_q[wr_ptr_q] <= first_item;
    end
    if (ev_x_vld && ev_y_vld) begin
      evq_q[wr_ptr_q + EvqAw'(1)] <= second_item;
    end
  end

  // Result channel.
  assign key_o.valid      = (cnt_q != '0);
  assign key_o.key_code   = evq_q[rd_ptr_q].key_code;
  assign key_o.pressed    = evq_q[rd_ptr_q].pressed;
  assign key_o.last_event = evq_q[rd_ptr_q].last_event;

`ifndef ASSERT_OFF
  // The queue never holds more items than it has entries.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= EvqCntW'(EvqDepth))
    else $error("key queue overflow");

  // A light sample only releases keys.
  a_light_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_use && !heavy) |-> !(ev_x_vld && x_res.pressed) && !(ev_y_vld && y_res.pressed))
    else $error("key press on a light sample");

  // A light sample leaves both axes neutral.
  a_light_neutral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_use && !heavy) |=> (h_dir_q == DIR_NEUTRAL) && (v_dir_q == DIR_NEUTRAL))
    else $error("axis held after a light sample");

  // A release item is only produced for a held x key.
  a_release_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_x_vld && !x_res.pressed) |-> (h_dir_q != DIR_NEUTRAL))
    else $error("release without a held key");
`endif

endmodule
